/* rtl/fcsg_pkg.sv */
// Package: constants, codes and helper functions for the four-channel sound generator.
package fcsg_pkg;

	localparam int FRAME_TICKS  = 8192;
	localparam int SAMPLE_TICKS = 95;

	// Reciprocal for the per-sample average: q = (x * DIV_M) >> DIV_K is exact for 15-bit x
	localparam int DIV_K  = 22;
	localparam int DIV_MW = 23;
	localparam logic [DIV_MW-1:0] DIV_M = DIV_MW'((2**DIV_K + SAMPLE_TICKS - 1) / SAMPLE_TICKS);

	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_READ  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	// Bus addresses with a special meaning
	localparam logic [7:0] ADDR_CH1_HI = 8'h14;
	localparam logic [7:0] ADDR_CH2_HI = 8'h19;
	localparam logic [7:0] ADDR_CH3_HI = 8'h1E;
	localparam logic [7:0] ADDR_CH4_HI = 8'h23;
	localparam logic [7:0] ADDR_POWER  = 8'h26;
	localparam logic [3:0] ADDR_WAVE_PAGE = 4'h3;

	// Register file indexes
	localparam logic [4:0] REG_SWEEP      = 5'd0;
	localparam logic [4:0] REG_CH1_FLO    = 5'd3;
	localparam logic [4:0] REG_CH1_FHI    = 5'd4;
	localparam logic [4:0] REG_WAVE_ON    = 5'd9;
	localparam logic [4:0] REG_NOISE_POLY = 5'd16;
	localparam logic [4:0] REG_POWER      = 5'd20;
	localparam int NUM_REGS = 21;

	typedef struct packed {
		logic       hit;
		logic [4:0] idx;
	} reg_sel_t;

	// Map a bus address to a register file index
	function automatic reg_sel_t reg_index(input logic [7:0] a);
		reg_sel_t r;
		r.hit = 1'b1;
		r.idx = 5'd0;
		priority if (a >= 8'h10 && a <= 8'h14) r.idx = 5'(a - 8'h10);
		else if (a >= 8'h16 && a <= 8'h19) r.idx = 5'(a - 8'h16 + 8'd5);
		else if (a >= 8'h1A && a <= 8'h1E) r.idx = 5'(a - 8'h1A + 8'd9);
		else if (a >= 8'h20 && a <= 8'h23) r.idx = 5'(a - 8'h20 + 8'd14);
		else if (a >= 8'h24 && a <= 8'h26) r.idx = 5'(a - 8'h24 + 8'd18);
		else r.hit = 1'b0;
		return r;
	endfunction

	// Index of each channel's length register, the first of the four that a trigger reads
	function automatic logic [4:0] chan_base(input logic [1:0] c);
		logic [4:0] b;
		unique case (c)
			2'd0: b = 5'd1;
			2'd1: b = 5'd5;
			2'd2: b = 5'd10;
			default: b = 5'd14;
		endcase
		return b;
	endfunction

	// Pulse duty pattern: mask for the given duty code and step
	function automatic logic [7:0] duty_mask(input logic [1:0] duty, input logic [2:0] stp);
		logic [31:0] pat;
		logic [4:0]  i;
		pat = 32'b0111_1110_1110_0001_1000_0001_1000_0000;
		i   = {duty, stp};
		return pat[i] ? 8'hF0 : 8'h00;
	endfunction

endpackage

/* rtl/four_channel_sound_generator_core.sv */
// Four-channel sound generator: register state, channel update and sample pipeline.
//
// Usage: each transaction on the input channel (in_valid/in_stall) carries
// kind, addr and wdata. kind selects a clock tick, a register write, a
// register read or no operation. Every input transaction yields exactly one output
// transaction (out_valid/out_stall) carrying rdata, sample_ready and sample.
// Register state is updated in the cycle the input transaction is taken;
// the result then runs through three registered stages (capture, averaging
// multiply, final add) before out_valid rises and the result can be taken.
// One transaction is accepted per cycle while in_stall is low; the rate rests
// on all four channels being updated in the cycle a transaction is taken.
// A stall on the output holds the output register and fills the stages
// behind it one at a time; in_stall rises only when all three are full.
// Reset (arst_n low) clears registers, wave RAM, channel state and the
// pipeline valid flags (not the pipeline data); the frame countdown restarts
// at its full value and the frame step at seven.
module four_channel_sound_generator_core
	import fcsg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] kind,
	input  logic [7:0] addr,
	input  logic [7:0] wdata,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] rdata,
	output logic       sample_ready,
	output logic [9:0] sample
);

	// Architectural state
	logic [7:0]  regs_q [NUM_REGS];
	logic [7:0]  wave_q [16];
	logic [3:0]  chan_on_q;
	logic [8:0]  len_q [4];
	logic [3:0]  len_gate_q;
	logic [22:0] pcnt_q [4];
	logic [22:0] prel_q [4];
	logic [4:0]  step_q [4];
	logic [3:0]  env_per_q [4];
	logic [3:0]  env_rise_q;
	logic [3:0]  env_cnt_q [4];
	logic [3:0]  level_q [4];
	logic [3:0]  swp_per_q, swp_cnt_q;
	logic [11:0] swp_freq_q;
	logic        swp_act_q;
	logic [15:0] noise_q;
	logic [13:0] frame_cnt_q;
	logic [2:0]  frame_step_q;
	logic [14:0] mix_q [4];
	logic [6:0]  smp_cnt_q;

	// Next-state values
	logic [7:0]  regs_d [NUM_REGS];
	logic [7:0]  wave_d [16];
	logic [3:0]  chan_on_d;
	logic [8:0]  len_d [4];
	logic [3:0]  len_gate_d;
	logic [22:0] pcnt_d [4];
	logic [22:0] prel_d [4];
	logic [4:0]  step_d [4];
	logic [3:0]  env_per_d [4];
	logic [3:0]  env_rise_d;
	logic [3:0]  env_cnt_d [4];
	logic [3:0]  level_d [4];
	logic [3:0]  swp_per_d, swp_cnt_d;
	logic [11:0] swp_freq_d;
	logic        swp_act_d;
	logic [15:0] noise_d;
	logic [13:0] frame_cnt_d;
	logic [2:0]  frame_step_d;
	logic [14:0] mix_d [4];
	logic [6:0]  smp_cnt_d;

	// Per-transaction results and temporaries
	logic [7:0]  res_rdata;
	logic        res_ready;
	logic [14:0] res_mix [4];
	logic [11:0] delta;
	logic [12:0] nf;
	logic [11:0] span;
	logic [7:0]  add, wbyte;
	logic        nv;
	logic        trig;
	logic [1:0]  tc;
	logic [4:0]  tb;
	logic [7:0]  x1, x2, x3, x4;
	logic [10:0] fq;
	logic [6:0]  nr;
	reg_sel_t    rsel;

	// Pipeline
	logic        s1_valid, s2_valid;
	logic        ld1, ld2, ld3, in_acc;
	logic [7:0]  rdata_s1, rdata_s2;
	logic        ready_s1, ready_s2;
	logic [14:0] mix_s1 [4];
	logic [14:0] quo_s2 [4];

	assign ld3      = !out_valid || !out_stall;
	assign ld2      = !s2_valid || ld3;
	assign ld1      = !s1_valid || ld2;
	assign in_stall = !ld1;
	assign in_acc   = in_valid && !in_stall;

	// Compute the state after one transaction
	always_comb begin
		regs_d = regs_q; wave_d = wave_q; chan_on_d = chan_on_q; len_d = len_q;
		len_gate_d = len_gate_q; pcnt_d = pcnt_q; prel_d = prel_q; step_d = step_q;
		env_per_d = env_per_q; env_rise_d = env_rise_q; env_cnt_d = env_cnt_q;
		level_d = level_q; swp_per_d = swp_per_q; swp_cnt_d = swp_cnt_q;
		swp_freq_d = swp_freq_q; swp_act_d = swp_act_q; noise_d = noise_q;
		frame_cnt_d = frame_cnt_q; frame_step_d = frame_step_q; mix_d = mix_q;
		smp_cnt_d = smp_cnt_q;
		res_rdata = 8'h00; res_ready = 1'b0; res_mix = mix_q;
		delta = '0; nf = '0; span = '0; add = '0; wbyte = '0; nv = 1'b0;
		trig = 1'b0; tc = 2'd0; tb = '0; x1 = '0; x2 = '0; x3 = '0; x4 = '0;
		fq = '0; nr = '0;
		rsel = reg_index(addr);
		if (in_acc) begin
			unique case (kind_t'(kind))
				KIND_TICK: begin
					// Frame sequencer
					frame_cnt_d = 14'(frame_cnt_q - 14'd1);
					if (frame_cnt_d == 14'd0) begin
						frame_cnt_d  = 14'(FRAME_TICKS);
						frame_step_d = 3'(frame_step_q + 3'd1);
						if (!frame_step_d[0]) begin
							for (int i = 0; i < 4; i++) begin
								if (chan_on_d[i] && len_gate_d[i]) begin
									len_d[i] = 9'(len_d[i] - 9'd1);
									if (len_d[i] == 9'd0) chan_on_d[i] = 1'b0;
								end
							end
						end
						if (frame_step_d[1:0] == 2'd2 && swp_act_q) begin
							if (swp_cnt_q > 4'd1) begin
								swp_cnt_d = 4'(swp_cnt_q - 4'd1);
							end else begin
								swp_cnt_d = swp_per_q;
								delta = swp_freq_q >> regs_q[REG_SWEEP][2:0];
								if (regs_q[REG_SWEEP][3]) nf = {1'b0, swp_freq_q} - {1'b0, delta};
								else nf = {1'b0, swp_freq_q} + {1'b0, delta};
								if (nf > 13'd2047) begin
									swp_freq_d   = nf[12] ? 12'hFFF : nf[11:0];
									chan_on_d[0] = 1'b0;
								end else begin
									swp_freq_d = nf[11:0];
									regs_d[REG_CH1_FLO] = nf[7:0];
									regs_d[REG_CH1_FHI] = {regs_q[REG_CH1_FHI][7:3], nf[10:8]};
									span = 12'(12'd2048 - nf[11:0]);
									prel_d[0] = {9'd0, span, 2'b00};
								end
							end
						end
						if (frame_step_d == 3'd7) begin
							for (int i = 0; i < 4; i++) begin
								if (i != 2 && env_cnt_q[i] != 4'd0) begin
									env_cnt_d[i] = 4'(env_cnt_q[i] - 4'd1);
									if (env_cnt_d[i] == 4'd0) begin
										env_cnt_d[i] = env_per_q[i];
										if (env_rise_q[i]) begin
											if (level_q[i] < 4'd15) level_d[i] = 4'(level_q[i] + 4'd1);
										end else begin
											if (level_q[i] > 4'd0) level_d[i] = 4'(level_q[i] - 4'd1);
										end
									end
								end
							end
						end
					end
					// Period timers and accumulators
					for (int i = 0; i < 4; i++) begin
						if (chan_on_d[i]) begin
							if (pcnt_q[i] <= 23'd1) begin
								pcnt_d[i] = prel_d[i];
								if (i == 2) step_d[i] = 5'(step_q[i] + 5'd1);
								else if (i == 3) begin
									nv = noise_q[0] ^ noise_q[1];
									noise_d = {nv, noise_q[15:1]};
									if (regs_q[REG_NOISE_POLY][3]) noise_d[6] = nv;
								end else step_d[i] = {2'b00, 3'(step_q[i][2:0] + 3'd1)};
							end else begin
								pcnt_d[i] = 23'(pcnt_q[i] - 23'd1);
							end
							if (i == 2) begin
								wbyte = wave_q[step_d[2][4:1]];
								add = step_d[2][0] ? {wbyte[7:4], 4'h0} : {wbyte[3:0], 4'h0};
							end else if (i == 3) begin
								add = noise_d[0] ? 8'h00 : {level_d[3], 4'h0};
							end else begin
								add = duty_mask(regs_q[chan_base(2'(i))][7:6], step_d[i][2:0])
									& {level_d[i], 4'h0};
							end
							mix_d[i] = 15'(mix_q[i] + {7'd0, add});
						end
					end
					// Close the sample window
					smp_cnt_d = 7'(smp_cnt_q + 7'd1);
					if (smp_cnt_d >= 7'(SAMPLE_TICKS)) begin
						smp_cnt_d = 7'd0;
						res_ready = 1'b1;
						res_mix   = mix_d;
						for (int i = 0; i < 4; i++) mix_d[i] = 15'd0;
					end
				end
				KIND_WRITE: begin
					if (addr[7:4] == ADDR_WAVE_PAGE) begin
						wave_d[addr[3:0]] = wdata;
					end else if (addr == ADDR_POWER) begin
						regs_d[REG_POWER] = wdata;
						if (!wdata[7]) chan_on_d = 4'd0;
					end else if (regs_q[REG_POWER][7] && rsel.hit) begin
						regs_d[rsel.idx] = wdata;
						if (wdata[7]) begin
							trig = 1'b1;
							priority case (addr)
								ADDR_CH1_HI: tc = 2'd0;
								ADDR_CH2_HI: tc = 2'd1;
								ADDR_CH3_HI: tc = 2'd2;
								ADDR_CH4_HI: tc = 2'd3;
								default: trig = 1'b0;
							endcase
						end
					end
					// Trigger a channel
					tb = chan_base(tc);
					x1 = regs_d[tb];
					x2 = regs_d[5'(tb + 5'd1)];
					x3 = regs_d[5'(tb + 5'd2)];
					x4 = regs_d[5'(tb + 5'd3)];
					fq = {x4[2:0], x3};
					if (trig && !(tc == 2'd2 && !regs_d[REG_WAVE_ON][7])) begin
						chan_on_d[tc]  = 1'b1;
						len_gate_d[tc] = x4[6];
						len_d[tc] = (tc == 2'd2) ? 9'(9'd256 - {1'b0, x1})
							: 9'(9'd64 - {3'd0, x1[5:0]});
						step_d[tc]     = 5'd0;
						level_d[tc]    = x2[7:4];
						env_rise_d[tc] = x2[3];
						env_per_d[tc]  = (x2[2:0] != 3'd0) ? {1'b0, x2[2:0]} : 4'd8;
						env_cnt_d[tc]  = env_per_d[tc];
						span = 12'(12'd2048 - {1'b0, fq});
						if (tc == 2'd3) begin
							nr = (x3[2:0] != 3'd0) ? {x3[2:0], 4'h0} : 7'd8;
							noise_d = 16'h7FFF;
							prel_d[3] = 23'({16'd0, nr} << ({1'b0, x3[7:4]} + 5'd1));
						end else if (tc == 2'd2) begin
							prel_d[2] = {10'd0, span, 1'b0};
						end else begin
							prel_d[tc] = {9'd0, span, 2'b00};
						end
						pcnt_d[tc] = prel_d[tc];
						if (tc == 2'd0) begin
							swp_freq_d = {1'b0, fq};
							swp_per_d  = (regs_d[REG_SWEEP][6:4] != 3'd0)
								? {1'b0, regs_d[REG_SWEEP][6:4]} : 4'd8;
							swp_cnt_d  = swp_per_d;
							swp_act_d  = |regs_d[REG_SWEEP][6:4];
						end
					end
				end
				KIND_READ: begin
					if (addr[7:4] == ADDR_WAVE_PAGE) res_rdata = wave_q[addr[3:0]];
					else if (addr == ADDR_POWER) res_rdata = {regs_q[REG_POWER][7], 3'd0, chan_on_q};
					else if (rsel.hit) res_rdata = regs_q[rsel.idx];
					else res_rdata = 8'hFF;
				end
				default: ;
			endcase
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) regs_q[i] <= 8'd0;
			for (int i = 0; i < 16; i++) wave_q[i] <= 8'd0;
			for (int i = 0; i < 4; i++) begin
				len_q[i] <= '0; pcnt_q[i] <= '0; prel_q[i] <= '0; step_q[i] <= '0;
				env_per_q[i] <= '0; env_cnt_q[i] <= '0; level_q[i] <= '0; mix_q[i] <= '0;
			end
			chan_on_q <= '0; len_gate_q <= '0; env_rise_q <= '0;
			swp_per_q <= '0; swp_cnt_q <= '0; swp_freq_q <= '0; swp_act_q <= 1'b0;
			noise_q <= '0; frame_cnt_q <= 14'(FRAME_TICKS); frame_step_q <= 3'd7;
			smp_cnt_q <= '0;
		end else begin
			regs_q <= regs_d; wave_q <= wave_d; chan_on_q <= chan_on_d; len_q <= len_d;
			len_gate_q <= len_gate_d; pcnt_q <= pcnt_d; prel_q <= prel_d; step_q <= step_d;
			env_per_q <= env_per_d; env_rise_q <= env_rise_d; env_cnt_q <= env_cnt_d;
			level_q <= level_d; swp_per_q <= swp_per_d; swp_cnt_q <= swp_cnt_d;
			swp_freq_q <= swp_freq_d; swp_act_q <= swp_act_d; noise_q <= noise_d;
			frame_cnt_q <= frame_cnt_d; frame_step_q <= frame_step_d; mix_q <= mix_d;
			smp_cnt_q <= smp_cnt_d;
		end
	end

	// Pipeline valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid  <= 1'b0;
			s2_valid  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (ld1) s1_valid  <= in_acc;
			if (ld2) s2_valid  <= s1_valid;
			if (ld3) out_valid <= s2_valid;
		end
	end

	// Capture, average and sum the channel totals
	always_ff @(posedge clk) begin
		if (ld1) begin
			rdata_s1 <= res_rdata;
			ready_s1 <= res_ready;
			for (int i = 0; i < 4; i++) mix_s1[i] <= res_ready ? res_mix[i] : 15'd0;
		end
		if (ld2) begin
			rdata_s2 <= rdata_s1;
			ready_s2 <= ready_s1;
			for (int i = 0; i < 4; i++)
				quo_s2[i] <= 15'(({{DIV_MW{1'b0}}, mix_s1[i]} * {15'd0, DIV_M}) >> DIV_K);
		end
		if (ld3) begin
			rdata        <= rdata_s2;
			sample_ready <= ready_s2;
			sample       <= 10'(17'({2'b0, quo_s2[0]} + {2'b0, quo_s2[1]})
				+ 17'({2'b0, quo_s2[2]} + {2'b0, quo_s2[3]}));
		end
	end

`ifndef SYNTHESIS
	a_ready_no_rdata: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sample_ready |-> rdata == 8'd0)
		else $error("sample transaction carries read data");
	a_sample_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !sample_ready |-> sample == 10'd0)
		else $error("sample value without sample_ready");
	a_power_off: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && kind == KIND_WRITE && addr == ADDR_POWER && !wdata[7] |=> chan_on_q == 4'd0)
		else $error("channels still on after power off");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !ld2 |-> in_stall)
		else $error("input taken while capture stage is held");
`endif

endmodule
